// File: rtl/stiv_pkg.sv
// Shared types and constants for the stripe image video memory writer.
// No dependencies; imported by the parser, the output buffer and the top level.
package stiv_pkg;

	localparam int ADDR_W_MAX = 16;
	localparam int IDX_W      = 14;
	localparam int LEFT_W     = 15;

	localparam logic [15:0] SKIP_ADDR  = 16'hFFFF;
	localparam int          END_BIT    = 7;
	localparam int          VERT_BIT   = 7;
	localparam int          FILL_BIT   = 6;

	// Parser position within the stripe list
	typedef enum logic [7:0] {
		PH_ADDR_HI  = 8'b0000_0001,
		PH_ADDR_LO  = 8'b0000_0010,
		PH_FLAGS    = 8'b0000_0100,
		PH_LENGTH   = 8'b0000_1000,
		PH_COPY     = 8'b0001_0000,
		PH_FILL_LO  = 8'b0010_0000,
		PH_FILL_HI  = 8'b0100_0000,
		PH_FILL_RUN = 8'b1000_0000
	} phase_t;

	// One result beat
	typedef struct packed {
		logic                  write_valid;
		logic [ADDR_W_MAX-1:0] word_address;
		logic [15:0]           write_data;
		logic                  enable_low;
		logic                  enable_high;
		logic                  list_done;
		logic                  overrun_error;
	} res_t;

endpackage

// File: rtl/stiv_parser.sv
// Stripe list parser: header decode, copy/fill sequencing and write address generation.
// Depends on stiv_pkg.
module stiv_parser #(
	parameter int ADDRESS_BITS    = 15,
	parameter int VERTICAL_STRIDE = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          go,
	input  logic          cmd,
	input  logic [7:0]    stream_byte,
	output stiv_pkg::res_t res
);
	import stiv_pkg::*;

	localparam int SW    = $clog2(VERTICAL_STRIDE + 1);
	localparam int PW    = IDX_W + SW;
	localparam int SUM_W = PW + 2;

	phase_t               phase_q, phase_n;
	logic [15:0]          target_q, target_n;
	logic [7:0]           flag_q, flag_n;
	logic [LEFT_W-1:0]    left_q, left_n;
	logic [7:0]           held_q, held_n;
	logic [15:0]          fill_word_q, fill_word_n;
	logic [IDX_W-1:0]     fill_left_q, fill_left_n;
	logic                 tail_q, tail_n;
	logic [IDX_W-1:0]     idx_q, idx_n;

	logic                 emit;
	logic [IDX_W-1:0]     emit_idx;
	logic                 emit_vert;
	logic [15:0]          emit_data;
	logic                 emit_lo, emit_hi;
	logic                 done, overrun;
	logic [15:0]          cnt_inc;
	logic [LEFT_W-1:0]    cnt_half;
	logic [PW-1:0]        scaled;
	logic [SUM_W-1:0]     addr_sum;
	logic [ADDR_W_MAX-1:0] addr;

	assign cnt_inc  = 16'(left_q) + 16'd1;
	assign cnt_half = cnt_inc[15:1];

	always_comb begin
		phase_n     = phase_q;
		target_n    = target_q;
		flag_n      = flag_q;
		left_n      = left_q;
		held_n      = held_q;
		fill_word_n = fill_word_q;
		fill_left_n = fill_left_q;
		tail_n      = tail_q;
		idx_n       = idx_q;
		emit        = 1'b0;
		emit_idx    = idx_q;
		emit_vert   = flag_q[VERT_BIT];
		emit_data   = '0;
		emit_lo     = 1'b0;
		emit_hi     = 1'b0;
		done        = 1'b0;
		overrun     = 1'b0;
		if (cmd) begin
			if (phase_q == PH_FILL_RUN) begin
				if (fill_left_q != '0) begin
					emit        = 1'b1;
					emit_data   = fill_word_q;
					emit_lo     = 1'b1;
					emit_hi     = 1'b1;
					idx_n       = idx_q + 1'b1;
					fill_left_n = fill_left_q - 1'b1;
				end else if (tail_q) begin
					// closing half word: low fill byte goes to the high lane
					emit      = 1'b1;
					emit_vert = 1'b0;
					emit_data = {fill_word_q[7:0], 8'h00};
					emit_hi   = 1'b1;
					tail_n    = 1'b0;
				end
				if (fill_left_n == '0 && !tail_n)
					phase_n = PH_ADDR_HI;
			end
		end else begin
			case (phase_q)
				PH_ADDR_HI: begin
					if (stream_byte[END_BIT]) begin
						done = 1'b1;
					end else begin
						target_n = {stream_byte, 8'h00};
						phase_n  = PH_ADDR_LO;
					end
				end
				PH_ADDR_LO: begin
					target_n = {target_q[15:8], stream_byte};
					phase_n  = PH_FLAGS;
				end
				PH_FLAGS: begin
					flag_n  = stream_byte;
					phase_n = PH_LENGTH;
				end
				PH_LENGTH: begin
					left_n  = LEFT_W'({flag_q[5:0], stream_byte}) + 1'b1;
					idx_n   = '0;
					tail_n  = 1'b0;
					phase_n = flag_q[FILL_BIT] ? PH_FILL_LO : PH_COPY;
				end
				PH_COPY: begin
					if (!tail_q) begin
						held_n = stream_byte;
						tail_n = 1'b1;
					end else begin
						if (target_q != SKIP_ADDR) begin
							emit      = 1'b1;
							emit_data = {stream_byte, held_q};
							emit_lo   = 1'b1;
							emit_hi   = 1'b1;
						end
						idx_n  = idx_q + 1'b1;
						tail_n = 1'b0;
					end
					left_n = left_q - 1'b1;
					// drop an odd trailing byte
					if (left_n == '0) begin
						tail_n  = 1'b0;
						phase_n = PH_ADDR_HI;
					end
				end
				PH_FILL_LO: begin
					held_n  = stream_byte;
					phase_n = PH_FILL_HI;
				end
				PH_FILL_HI: begin
					fill_word_n = {stream_byte, held_q};
					if (target_q == SKIP_ADDR) begin
						phase_n = PH_ADDR_HI;
					end else begin
						tail_n      = !flag_q[VERT_BIT] && !left_q[0];
						emit        = 1'b1;
						emit_idx    = '0;
						emit_data   = {stream_byte, held_q};
						emit_lo     = 1'b1;
						emit_hi     = 1'b1;
						idx_n       = IDX_W'(1);
						fill_left_n = IDX_W'(cnt_half - 1'b1);
						phase_n     = (fill_left_n == '0 && !tail_n) ? PH_ADDR_HI : PH_FILL_RUN;
					end
				end
				default: begin
					// byte during a fill run: flag and drop
					overrun = 1'b1;
				end
			endcase
		end
	end

	always_comb begin
		if (emit_vert)
			scaled = PW'(emit_idx * VERTICAL_STRIDE);
		else
			scaled = PW'(emit_idx);
	end

	assign addr_sum = SUM_W'(target_q) + SUM_W'(scaled);
	assign addr     = ADDR_W_MAX'(addr_sum[ADDRESS_BITS-1:0]);

	always_comb begin
		res               = '0;
		res.write_valid   = emit;
		res.word_address  = emit ? addr : '0;
		res.write_data    = emit_data;
		res.enable_low    = emit_lo;
		res.enable_high   = emit_hi;
		res.list_done     = done;
		res.overrun_error = overrun;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_ADDR_HI;
			target_q    <= '0;
			flag_q      <= '0;
			left_q      <= '0;
			held_q      <= '0;
			fill_word_q <= '0;
			fill_left_q <= '0;
			tail_q      <= 1'b0;
			idx_q       <= '0;
		end else if (go) begin
			phase_q     <= phase_n;
			target_q    <= target_n;
			flag_q      <= flag_n;
			left_q      <= left_n;
			held_q      <= held_n;
			fill_word_q <= fill_word_n;
			fill_left_q <= fill_left_n;
			tail_q      <= tail_n;
			idx_q       <= idx_n;
		end
	end

	a_write_has_lane: assert property (@(posedge clk) disable iff (!arst_n)
		res.write_valid |-> (res.enable_low || res.enable_high))
		else $error("write beat without byte enable");

	a_done_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		res.list_done |-> !res.write_valid && !res.overrun_error)
		else $error("end marker beat also carries a write or overrun");

	a_run_has_work: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_FILL_RUN) |-> (fill_left_q != '0 || tail_q))
		else $error("fill run entered with nothing left to write");

endmodule

// File: rtl/stiv_out_buf.sv
// Result register with a one-entry skid stage between the parser and the output channel.
// Depends on stiv_pkg.
module stiv_out_buf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  stiv_pkg::res_t din,
	output logic           full,
	output logic           out_valid,
	input  logic           out_stall,
	output stiv_pkg::res_t dout
);
	import stiv_pkg::*;

	logic out_q, skid_q;
	res_t out_data_q, skid_data_q;
	logic pop;

	assign pop       = out_q && !out_stall;
	assign full      = skid_q;
	assign out_valid = out_q;
	assign dout      = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_q  <= 1'b0;
			skid_q <= 1'b0;
		end else if (skid_q) begin
			if (pop)
				skid_q <= 1'b0;
		end else if (push) begin
			out_q <= 1'b1;
			// hold the beat aside while the output is stalled
			if (out_q && !pop)
				skid_q <= 1'b1;
		end else if (pop) begin
			out_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_q) begin
			if (pop)
				out_data_q <= skid_data_q;
		end else if (push) begin
			if (!out_q || pop)
				out_data_q <= din;
			else
				skid_data_q <= din;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_q |-> out_q)
		else $error("skid entry held with empty output register");

	a_skid_only_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_q) |-> $past(out_q && out_stall && push))
		else $error("skid entry filled without a stalled output");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !skid_q && !push) |=> !out_q)
		else $error("output beat repeated after it was taken");

endmodule

// File: rtl/stripe_image_vram_writer.sv
// Top level of the stripe image video memory writer.
// Depends on stiv_pkg, stiv_parser and stiv_out_buf.
//
// Usage:
//   Input channel (in_valid/in_stall, cmd, stream_byte): each beat is either a
//   stream byte (cmd 0) or a tick (cmd 1) that advances a pending fill run.
//   Output channel (out_valid/out_stall and the result fields): exactly one
//   result beat per input beat, in order. write_valid marks a memory write;
//   list_done marks the end marker byte, overrun_error a byte that arrived
//   during a fill run and was dropped.
//   Each result is held in the result register, or in the skid entry while stalled.
//   Throughput: one beat per cycle while in_stall is low; the header decode and
//   address add (index, times stride for vertical stripes, plus base) sit
//   between the parser state and the result register.
//   Stall: a result register plus one skid entry absorb output stalls;
//   in_stall rises only once both are occupied and falls when the output drains.
//   Reset: arst_n clears the parser to expect a first header byte and empties
//   the output register; no clearing pass is needed.
module stripe_image_vram_writer #(
	parameter int ADDRESS_BITS    = 15,
	parameter int VERTICAL_STRIDE = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    cmd,
	input  logic [7:0]              stream_byte,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    write_valid,
	output logic [ADDRESS_BITS-1:0] word_address,
	output logic [15:0]             write_data,
	output logic                    enable_low,
	output logic                    enable_high,
	output logic                    list_done,
	output logic                    overrun_error
);
	import stiv_pkg::*;

	logic go;
	res_t res;
	res_t res_out;
	logic full;

	assign go       = in_valid && !full;
	assign in_stall = full;

	stiv_parser #(
		.ADDRESS_BITS    (ADDRESS_BITS),
		.VERTICAL_STRIDE (VERTICAL_STRIDE)
	) u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (go),
		.cmd         (cmd),
		.stream_byte (stream_byte),
		.res         (res)
	);

	stiv_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (go),
		.din       (res),
		.full      (full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.dout      (res_out)
	);

	assign write_valid   = res_out.write_valid;
	assign word_address  = res_out.word_address[ADDRESS_BITS-1:0];
	assign write_data    = res_out.write_data;
	assign enable_low    = res_out.enable_low;
	assign enable_high   = res_out.enable_high;
	assign list_done     = res_out.list_done;
	assign overrun_error = res_out.overrun_error;

endmodule
